// ----- rtl/nps_pkg.sv -----
// Package for the nearest point search block: field widths, command codes,
// transaction structs and controller/datapath command and status buses.
// No dependencies.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int CoordBits         = 16;
    localparam int SlotBits          = 6;
    localparam int KindBits          = 4;
    localparam int CmdBits           = 2;
    localparam int SqBits            = 2 * CoordBits;
    localparam int DistBits          = SqBits + 1;
    localparam int DefaultTableDepth = 64;

    localparam logic [DistBits-1:0] DistBoundReset = DistBits'(1000000000);

    typedef enum logic [CmdBits-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_MATCH   = 2'd1,
        CMD_EXCLUDE = 2'd2
    } nps_cmd_t;

    typedef struct packed {
        logic [CmdBits-1:0]          command;
        logic [SlotBits-1:0]         slot;
        logic signed [CoordBits-1:0] px;
        logic signed [CoordBits-1:0] py;
        logic [KindBits-1:0]         kind;
        logic                        live;
    } nps_item_t;

    typedef struct packed {
        logic                found;
        logic [SlotBits-1:0] best_slot;
        logic [DistBits-1:0] best_dist_sq;
    } nps_result_t;

    typedef struct packed {
        logic load_query;
        logic write_entry;
        logic scan_step;
    } nps_ctrl_t;

    typedef struct packed {
        logic scan_last;
        logic pipe_tail;
    } nps_status_t;

endpackage

// ----- rtl/nps_ctrl.sv -----
// Controller for the nearest point search block: accepts transactions,
// sequences the table scan and raises the result strobe.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [nps_pkg::CmdBits-1:0] command,
    input  nps_pkg::nps_status_t  status,
    output logic                  busy,
    output logic                  done,
    output nps_pkg::nps_ctrl_t    ctrl
);
    import nps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    logic   done_reg;
    logic   accept;
    logic   is_query;

    assign accept   = start && (state_reg == ST_IDLE);
    assign is_query = (command == CMD_MATCH) || (command == CMD_EXCLUDE);

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign ctrl.load_query  = accept;
    assign ctrl.write_entry = accept && (command == CMD_WRITE);
    assign ctrl.scan_step   = (state_reg == ST_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && is_query)
                        state_reg <= ST_SCAN;
                    done_reg <= accept && !is_query;
                end
                ST_SCAN:
                begin
                    if (status.scan_last)
                        state_reg <= ST_DRAIN;
                    done_reg <= 1'b0;
                end
                ST_DRAIN:
                begin
                    // last compare lands at this edge
                    if (status.pipe_tail)
                        state_reg <= ST_IDLE;
                    done_reg <= status.pipe_tail;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_tail_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        status.pipe_tail |-> state_reg == ST_DRAIN)
        else $error("pipeline tail outside drain");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_DRAIN))
        else $error("result strobe raised mid-scan");

    a_scan_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_query) |=> state_reg == ST_IDLE && done)
        else $error("non-query transaction did not report at once");
`endif

endmodule

// ----- rtl/nps_datapath.sv -----
// Datapath for the nearest point search block: point table, bound register,
// scan pipeline (read, square, sum and compare) and result registers.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_datapath #(
    parameter int TABLE_DEPTH = nps_pkg::DefaultTableDepth
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nps_pkg::nps_item_t           item,
    input  nps_pkg::nps_ctrl_t           ctrl,
    output nps_pkg::nps_status_t         status,
    output nps_pkg::nps_result_t         result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [nps_pkg::DistBits-1:0] cfg_data
);
    import nps_pkg::*;

    localparam int AddrBits = $clog2(TABLE_DEPTH);
    localparam int ExtBits  = ((AddrBits > SlotBits) ? AddrBits : SlotBits) + 1;

    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic [KindBits-1:0]         kind;
    } entry_t;

    entry_t                      entry_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]      live_reg;
    logic [DistBits-1:0]         max_dist_sq_reg;

    logic signed [CoordBits-1:0] q_x_reg;
    logic signed [CoordBits-1:0] q_y_reg;
    logic [KindBits-1:0]         q_kind_reg;
    logic                        q_exclude_reg;

    logic [AddrBits-1:0]         scan_addr_reg;
    logic                        s1_valid_reg;
    logic                        s2_valid_reg;
    entry_t                      rd_entry_reg;
    logic                        rd_live_reg;
    logic [AddrBits-1:0]         s1_idx_reg;
    logic [AddrBits-1:0]         s2_idx_reg;
    logic                        s2_hit_reg;
    logic [SqBits-1:0]           sq_x_reg;
    logic [SqBits-1:0]           sq_y_reg;

    logic                        found_reg;
    logic [SlotBits-1:0]         best_slot_reg;
    logic [DistBits-1:0]         best_dist_reg;

    logic [ExtBits-1:0]          slot_ext;
    logic [AddrBits-1:0]         wr_addr;
    logic                        wr_in_range;
    logic signed [CoordBits:0]   dx;
    logic signed [CoordBits:0]   dy;
    logic [CoordBits:0]          neg_dx;
    logic [CoordBits:0]          neg_dy;
    logic [CoordBits-1:0]        mag_x;
    logic [CoordBits-1:0]        mag_y;
    logic [DistBits-1:0]         dist_sum;
    logic [DistBits-1:0]         dist_bound;
    logic                        take;

    assign slot_ext    = ExtBits'(item.slot);
    assign wr_addr     = slot_ext[AddrBits-1:0];
    assign wr_in_range = (slot_ext < ExtBits'(TABLE_DEPTH));

    assign cfg_ready = 1'b1;

    assign status.scan_last = (scan_addr_reg == AddrBits'(TABLE_DEPTH - 1));
    assign status.pipe_tail = s2_valid_reg && !s1_valid_reg;

    assign result.found        = found_reg;
    assign result.best_slot    = best_slot_reg;
    assign result.best_dist_sq = best_dist_reg;

    // stage 2: absolute differences
    assign dx     = (CoordBits+1)'(rd_entry_reg.x) - (CoordBits+1)'(q_x_reg);
    assign dy     = (CoordBits+1)'(rd_entry_reg.y) - (CoordBits+1)'(q_y_reg);
    assign neg_dx = -dx;
    assign neg_dy = -dy;
    assign mag_x  = dx[CoordBits] ? neg_dx[CoordBits-1:0] : dx[CoordBits-1:0];
    assign mag_y  = dy[CoordBits] ? neg_dy[CoordBits-1:0] : dy[CoordBits-1:0];

    // stage 3: sum and strict compare against best so far or the bound
    assign dist_sum   = DistBits'(sq_x_reg) + DistBits'(sq_y_reg);
    assign dist_bound = found_reg ? best_dist_reg : max_dist_sq_reg;
    assign take       = s2_valid_reg && s2_hit_reg && (dist_sum < dist_bound);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg        <= '0;
            max_dist_sq_reg <= DistBoundReset;
            scan_addr_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_dist_sq_reg <= cfg_data;
            if (ctrl.write_entry && wr_in_range)
                live_reg[wr_addr] <= item.live;
            if (ctrl.load_query)
                scan_addr_reg <= '0;
            else if (ctrl.scan_step)
                scan_addr_reg <= scan_addr_reg + AddrBits'(1);
            s1_valid_reg <= ctrl.scan_step;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.write_entry && wr_in_range)
        begin
            entry_mem[wr_addr] <= '{x: item.px, y: item.py, kind: item.kind};
        end
        rd_entry_reg <= entry_mem[scan_addr_reg];
        rd_live_reg  <= live_reg[scan_addr_reg];
        s1_idx_reg   <= scan_addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_query)
        begin
            q_x_reg       <= item.px;
            q_y_reg       <= item.py;
            q_kind_reg    <= item.kind;
            q_exclude_reg <= (item.command == CMD_EXCLUDE);
        end
        s2_idx_reg <= s1_idx_reg;
        s2_hit_reg <= rd_live_reg && ((rd_entry_reg.kind == q_kind_reg) != q_exclude_reg);
        sq_x_reg   <= SqBits'(mag_x) * SqBits'(mag_x);
        sq_y_reg   <= SqBits'(mag_y) * SqBits'(mag_y);
    end

    always_ff @(posedge clk)
    begin
        priority if (ctrl.load_query)
        begin
            found_reg     <= 1'b0;
            best_slot_reg <= '0;
            best_dist_reg <= '0;
        end
        else if (take)
        begin
            found_reg     <= 1'b1;
            best_slot_reg <= SlotBits'(s2_idx_reg);
            best_dist_reg <= dist_sum;
        end
    end

`ifndef SYNTHESIS
    a_write_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.write_entry |-> !s1_valid_reg && !s2_valid_reg)
        else $error("table written while scan pipeline busy");
`endif

endmodule

// ----- rtl/nearest_point_search.sv -----
// Nearest point search: top level joining controller and datapath.
// Depends on nps_pkg, nps_ctrl and nps_datapath.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   item carries command, slot, px, py, kind and live. Command write stores
//   one table entry; match and exclude commands scan the table for the
//   nearest live entry of (or not of) the given kind whose squared distance
//   is strictly below the bound and below every earlier candidate.
//   Every transaction yields one result on result, valid for exactly one
//   cycle while done is high. The receiver cannot stall; the result must be
//   taken in that cycle.
//   A write or unused command reports in the cycle after acceptance. A query
//   reads one table entry per cycle; each read then passes the square and
//   the sum-and-compare registers before done is registered. Busy falls as
//   the result shows, so a new transaction can be taken in that cycle.
//   The bound is written over the cfg channel (cfg_valid/cfg_ready,
//   cfg_data) only while no transaction is in flight: a rule for the user,
//   not enforced by the block. Reset clears every live mark at once, sets
//   the bound to 1e9 and is ready on the first cycle after reset.
`timescale 1ns / 1ps

module nearest_point_search #(
    parameter int TABLE_DEPTH = nps_pkg::DefaultTableDepth
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  nps_pkg::nps_item_t           item,
    output logic                         done,
    output nps_pkg::nps_result_t         result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [nps_pkg::DistBits-1:0] cfg_data
);
    import nps_pkg::*;

    nps_ctrl_t   ctrl;
    nps_status_t status;

    nps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .status  (status),
        .busy    (busy),
        .done    (done),
        .ctrl    (ctrl)
    );

    nps_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .ctrl      (ctrl),
        .status    (status),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- test/nearest_point_search_tb.sv -----
// Self-checking testbench for nearest_point_search: directed and random table writes,
// match/exclude queries and bound changes, each result checked against a behavioural predictor.
// Depends on nps_pkg and the nearest_point_search RTL.
`timescale 1ns / 1ps

module nearest_point_search_tb;

    import nps_pkg::*;

    localparam int                  Depth       = DefaultTableDepth;
    localparam logic [CmdBits-1:0]  CmdUnused   = 2'd3;
    localparam logic [DistBits-1:0] BoundMax    = '1;
    localparam int                  DrainCycles = Depth + 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    nps_item_t   item;
    logic        done;
    nps_result_t result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [DistBits-1:0] cfg_data;

    // predictor state
    logic signed [CoordBits-1:0] pt_x    [Depth];
    logic signed [CoordBits-1:0] pt_y    [Depth];
    logic [KindBits-1:0]         pt_kind [Depth];
    bit                          pt_live [Depth];
    logic [DistBits-1:0]         bound_q;

    nps_result_t pending_results[$];

    bit gaps_on;
    int err_count;
    int n_writes;
    int n_queries;
    int n_hits;
    int n_unused;
    int n_bounds;

    nearest_point_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic nps_result_t nearest_of(input nps_item_t it);
        nps_result_t                 r;
        logic [DistBits-1:0]         limit;
        logic [DistBits-1:0]         d;
        logic signed [CoordBits:0]   dx;
        logic signed [CoordBits:0]   dy;
        logic [CoordBits-1:0]        ax;
        logic [CoordBits-1:0]        ay;
        bit                          same;
        r     = '0;
        limit = bound_q;
        if (it.command == CMD_MATCH || it.command == CMD_EXCLUDE)
        begin
            for (int i = 0; i < Depth; i++)
            begin
                if (!pt_live[i])
                    continue;
                same = (pt_kind[i] == it.kind);
                if ((it.command == CMD_MATCH) != same)
                    continue;
                dx = $signed({pt_x[i][CoordBits-1], pt_x[i]}) - $signed({it.px[CoordBits-1], it.px});
                dy = $signed({pt_y[i][CoordBits-1], pt_y[i]}) - $signed({it.py[CoordBits-1], it.py});
                ax = dx[CoordBits] ? CoordBits'(-dx) : dx[CoordBits-1:0];
                ay = dy[CoordBits] ? CoordBits'(-dy) : dy[CoordBits-1:0];
                d  = DistBits'(SqBits'(ax) * SqBits'(ax)) + DistBits'(SqBits'(ay) * SqBits'(ay));
                if (d < limit)
                begin
                    limit          = d;
                    r.found        = 1'b1;
                    r.best_slot    = i[SlotBits-1:0];
                    r.best_dist_sq = d;
                end
            end
        end
        return r;
    endfunction

    task automatic record_item(input nps_item_t it);
        nps_result_t r;
        r = nearest_of(it);
        pending_results = {pending_results, r};
        if (it.command == CMD_WRITE)
        begin
            pt_x[it.slot]    = it.px;
            pt_y[it.slot]    = it.py;
            pt_kind[it.slot] = it.kind;
            pt_live[it.slot] = it.live;
            n_writes++;
        end
        else if (it.command == CmdUnused)
            n_unused++;
        else
        begin
            n_queries++;
            if (r.found)
                n_hits++;
        end
    endtask

    task automatic send_item(input nps_item_t it);
        while (gaps_on && $urandom_range(99) < 35)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        if (gaps_on && $urandom_range(99) < 3)
        begin
            repeat ($urandom_range(70, 2))
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        record_item(it);
    endtask

    task automatic wr(input int slot, input int x, input int y, input int kind, input bit live);
        nps_item_t it;
        it.command = CMD_WRITE;
        it.slot    = SlotBits'(slot);
        it.px      = CoordBits'(x);
        it.py      = CoordBits'(y);
        it.kind    = KindBits'(kind);
        it.live    = live;
        send_item(it);
    endtask

    task automatic qry(input logic [CmdBits-1:0] cmd, input int x, input int y, input int kind);
        nps_item_t it;
        it.command = cmd;
        it.slot    = SlotBits'($urandom);
        it.px      = CoordBits'(x);
        it.py      = CoordBits'(y);
        it.kind    = KindBits'(kind);
        it.live    = $urandom_range(1);
        send_item(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_bound(input logic [DistBits-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        bound_q = v;
        n_bounds++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [CoordBits-1:0] pick_coord(input int span);
        int v;
        if ($urandom_range(99) < 20)
            return CoordBits'($urandom);
        v = int'($urandom_range(2 * span)) - span;
        return v[CoordBits-1:0];
    endfunction

    function automatic logic [KindBits-1:0] pick_kind();
        if ($urandom_range(99) < 75)
            return KindBits'($urandom_range(3));
        return KindBits'($urandom_range(15));
    endfunction

    function automatic nps_item_t make_item(input int span);
        nps_item_t   it;
        int unsigned roll;
        roll    = $urandom_range(99);
        it.slot = SlotBits'($urandom);
        it.px   = pick_coord(span);
        it.py   = pick_coord(span);
        it.kind = pick_kind();
        it.live = ($urandom_range(99) < 85);
        if (roll < 45)
            it.command = CMD_WRITE;
        else if (roll < 70)
            it.command = CMD_MATCH;
        else if (roll < 95)
            it.command = CMD_EXCLUDE;
        else
            it.command = CmdUnused;
        return it;
    endfunction

    task automatic test_empty_table();
        qry(CMD_MATCH, 0, 0, 0);
        qry(CMD_EXCLUDE, -1, 1, 15);
    endtask

    task automatic test_coord_extremes();
        wr(0, -32768, -32768, 15, 1'b1);
        wr(63, 32767, 32767, 15, 1'b1);
        qry(CMD_MATCH, 32767, 32767, 15);
        qry(CMD_MATCH, 0, 0, 15);
        set_bound(BoundMax);
        qry(CMD_MATCH, 32767, -32768, 15);
        qry(CMD_EXCLUDE, 32767, 32767, 0);
        wr(63, 32767, 32767, 15, 1'b0);
        qry(CMD_MATCH, 32767, 32767, 15);
    endtask

    task automatic test_ties_and_dead_entries();
        wr(10, 100, 100, 3, 1'b1);
        wr(5, 100, 100, 3, 1'b0);
        wr(20, 100, 100, 3, 1'b1);
        qry(CMD_MATCH, 101, 100, 3);
        wr(5, 100, 100, 3, 1'b1);
        qry(CMD_MATCH, 101, 100, 3);
    endtask

    task automatic test_modes();
        qry(CMD_EXCLUDE, 100, 100, 3);
        qry(CmdUnused, 100, 100, 3);
    endtask

    task automatic test_bound_edges();
        set_bound(DistBits'(1));
        qry(CMD_MATCH, 100, 100, 3);
        qry(CMD_MATCH, 101, 100, 3);
        set_bound(DistBits'(2));
        qry(CMD_MATCH, 101, 100, 3);
        set_bound('0);
        qry(CMD_MATCH, 100, 100, 3);
    endtask

    task automatic test_random(input int count, input int span, input logic [DistBits-1:0] bound);
        set_bound(bound);
        repeat (count) send_item(make_item(span));
    endtask

    always @(posedge clk)
    begin
        nps_result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.found !== exp_r.found)
                begin
                    err_count++;
                    $display("%0t: found expected %0d actual %0d",
                             $time, exp_r.found, result.found);
                end
                if (result.best_slot !== exp_r.best_slot)
                begin
                    err_count++;
                    $display("%0t: best_slot expected %0d actual %0d",
                             $time, exp_r.best_slot, result.best_slot);
                end
                if (result.best_dist_sq !== exp_r.best_dist_sq)
                begin
                    err_count++;
                    $display("%0t: best_dist_sq expected %0d actual %0d",
                             $time, exp_r.best_dist_sq, result.best_dist_sq);
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        bound_q   = DistBoundReset;
        for (int i = 0; i < Depth; i++)
        begin
            pt_x[i]    = '0;
            pt_y[i]    = '0;
            pt_kind[i] = '0;
            pt_live[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_coord_extremes();
        test_ties_and_dead_entries();
        test_modes();
        test_bound_edges();

        test_random(150, 20000, DistBoundReset);
        test_random(120, 32767, BoundMax);
        gaps_on = 1'b0;
        test_random(120, 40, DistBits'($urandom_range(5000, 1)));
        gaps_on = 1'b1;
        test_random(40, 200, '0);
        test_random(150, 8000, {1'($urandom), 32'($urandom)});
        test_random(70, 4, DistBoundReset);

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("tb: covered %0d writes, %0d queries (%0d hits), %0d unused commands",
                 n_writes, n_queries, n_hits, n_unused);
        $display("tb: %0d bound settings including zero and the maximum", n_bounds);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
